[rtl/sotc_pkg.sv]
// shared types and constants for the sustained over-temperature cutoff
package sotc_pkg;

  localparam int unsigned CutoffW   = 7;
  localparam int unsigned IntervalW = 16;
  localparam int unsigned SustainW  = 24;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned TempW     = 8;
  localparam int unsigned TripW     = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 24;

  localparam logic [CutoffW-1:0]   CutoffMax     = 7'd120;
  localparam logic [CutoffW-1:0]   CutoffReset   = 7'd85;
  localparam logic [IntervalW-1:0] IntervalReset = 16'd1000;
  localparam logic [SustainW-1:0]  SustainReset  = 24'd10000;
  localparam logic [TripW-1:0]     TripMax       = 16'hFFFF;

  // register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    REG_CUTOFF   = 2'd0,
    REG_INTERVAL = 2'd1,
    REG_SUSTAIN  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [CutoffW-1:0]   cutoff;
    logic [IntervalW-1:0] interval;
    logic [SustainW-1:0]  sustain;
  } cfg_t;

  typedef struct packed {
    logic [TimeW-1:0] last_sample;
    logic [TimeW-1:0] over_start;
    logic [TripW-1:0] trip;
  } state_t;

  typedef struct packed {
    logic             sampled;
    logic             over_pending;
    logic             shutdown;
    logic [TripW-1:0] trip_total;
  } result_t;

endpackage

[rtl/sotc_core.sv]
// per-tick decision logic: sample gating, over-temperature timing, trip count
module sotc_core (
  input  sotc_pkg::cfg_t                   cfg_i,
  input  sotc_pkg::state_t                 state_i,
  input  logic [sotc_pkg::TimeW-1:0]       time_ms_i,
  input  logic signed [sotc_pkg::TempW-1:0] temperature_i,
  output sotc_pkg::state_t                 state_o,
  output sotc_pkg::result_t                result_o
);
  import sotc_pkg::*;

  logic [TimeW-1:0] since_sample;
  logic [TimeW-1:0] since_over;
  logic             temp_pos;
  logic             temp_below;

  // wrap-safe elapsed times
  assign since_sample = time_ms_i - state_i.last_sample;
  assign since_over   = time_ms_i - state_i.over_start;

  // reading is positive and, if so, its low bits hold the full magnitude
  assign temp_pos   = !temperature_i[TempW-1] && (temperature_i != '0);
  assign temp_below = temperature_i[CutoffW-1:0] < cfg_i.cutoff;

  // next state and result
  always_comb begin
    state_o  = state_i;
    result_o = '0;
    if (cfg_i.cutoff != '0) begin
      if ((state_i.last_sample == '0) ||
          (since_sample >= {{(TimeW-IntervalW){1'b0}}, cfg_i.interval})) begin
        result_o.sampled    = 1'b1;
        state_o.last_sample = time_ms_i;
        if (temp_pos) begin
          if (temp_below) begin
            state_o.over_start = '0;
          end else if (state_i.over_start == '0) begin
            state_o.over_start = (time_ms_i == '0) ? TimeW'(1) : time_ms_i;
          end else if (since_over >= {{(TimeW-SustainW){1'b0}}, cfg_i.sustain}) begin
            result_o.shutdown   = 1'b1;
            state_o.last_sample = '0;
            state_o.over_start  = '0;
            if (state_i.trip != TripMax) begin
              state_o.trip = state_i.trip + TripW'(1);
            end
          end
        end
      end
    end
    result_o.over_pending = (state_o.over_start != '0);
    result_o.trip_total   = state_o.trip;
  end

endmodule

[rtl/sustained_overtemp_cutoff.sv]
// top level of the sustained over-temperature cutoff
// One tick per cycle sustained unless out_ready_i stalls: a beat lands in the input
// register, then its result is computed from the held state and loaded into the result
// register once that is free or being taken. The state update happens as the beat
// moves from the input register to the result register, so the following tick always
// sees it. in_ready_o drops only while the result register holds a beat not yet taken
// and the input register is full. cfg_ready_o is always high.
module sustained_overtemp_cutoff (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [sotc_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [sotc_pkg::CfgDataW-1:0]      cfg_data_i,
  // tick channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [sotc_pkg::TimeW-1:0]         time_ms_i,
  input  logic signed [sotc_pkg::TempW-1:0]  temperature_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               sampled_o,
  output logic                               over_pending_o,
  output logic                               shutdown_o,
  output logic [sotc_pkg::TripW-1:0]         trip_total_o
);
  import sotc_pkg::*;

  cfg_t                     cfg_q;
  state_t                   state_q;
  state_t                   state_d;
  state_t                   state_upd;
  result_t                  res_d;
  result_t                  res_q;
  logic                     out_valid_q;
  logic                     in_valid_q;
  logic [TimeW-1:0]         time_q;
  logic signed [TempW-1:0]  temp_q;
  logic                     advance;
  logic                     cfg_we;
  logic                     cutoff_wr;
  logic [CutoffW-1:0]       cutoff_clamped;

  // handshake control
  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;
  assign cutoff_wr   = cfg_we && (cfg_idx_e'(cfg_index_i) == REG_CUTOFF);

  // cutoff writes clamp at the maximum
  assign cutoff_clamped = (cfg_data_i[CutoffW-1:0] > CutoffMax) ? CutoffMax
                                                                : cfg_data_i[CutoffW-1:0];

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      time_q <= time_ms_i;
      temp_q <= temperature_i;
    end
  end

  // tick decision
  sotc_core u_core (
    .cfg_i         (cfg_q),
    .state_i       (state_q),
    .time_ms_i     (time_q),
    .temperature_i (temp_q),
    .state_o       (state_d),
    .result_o      (res_d)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cutoff   <= CutoffReset;
      cfg_q.interval <= IntervalReset;
      cfg_q.sustain  <= SustainReset;
    end else if (cfg_we) begin
      case (cfg_idx_e'(cfg_index_i))
        REG_CUTOFF:   cfg_q.cutoff   <= cutoff_clamped;
        REG_INTERVAL: cfg_q.interval <= cfg_data_i[IntervalW-1:0];
        REG_SUSTAIN:  cfg_q.sustain  <= cfg_data_i[SustainW-1:0];
        default:      cfg_q          <= cfg_q;
      endcase
    end
  end

  // next timer state; a cutoff write also clears the over-temperature timestamp
  always_comb begin
    state_upd = advance ? state_d : state_q;
    if (cutoff_wr) begin
      state_upd.over_start = '0;
    end
  end

  // timer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_upd;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sampled_o      = res_q.sampled;
  assign over_pending_o = res_q.over_pending;
  assign shutdown_o     = res_q.shutdown;
  assign trip_total_o   = res_q.trip_total;

endmodule

[rtl/sotc_checker.sv]
// port-level checks for the sustained over-temperature cutoff, with its bind
module sotc_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic                              sampled_o,
  input logic                              over_pending_o,
  input logic                              shutdown_o,
  input logic [sotc_pkg::TripW-1:0]        trip_total_o
);

  // a trip only happens on a sampled tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && shutdown_o) |-> sampled_o)
    else $error("shutdown without a sample");

  // a trip clears the over-temperature timer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && shutdown_o) |-> !over_pending_o)
    else $error("timer still pending after shutdown");

  // trip count only moves on a shutdown beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i) ##1 (out_valid_o && !shutdown_o)
      |-> (trip_total_o == $past(trip_total_o)))
    else $error("trip count changed without shutdown");

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(trip_total_o)
      && $stable(shutdown_o) && $stable(sampled_o)))
    else $error("stalled result beat changed");

endmodule

bind sustained_overtemp_cutoff sotc_checker u_sotc_checker (.*);

[verif/tb_sustained_overtemp_cutoff.sv]
// testbench for the sustained over-temperature cutoff: directed, random and back-to-back ticks
module tb_sustained_overtemp_cutoff;
  import sotc_pkg::*;

  localparam int unsigned CycleLimit = 40_000;
  // index with no register behind it, writes to it must be ignored
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;
  localparam logic signed [TempW-1:0] HotTemp = 8'sd100;

  // tracks the cutoff state and holds the expected result of every accepted tick
  class cutoff_scoreboard;
    logic [CutoffW-1:0]   cutoff;
    logic [IntervalW-1:0] interval;
    logic [SustainW-1:0]  sustain;
    logic [TimeW-1:0]     last_sample;
    logic [TimeW-1:0]     over_start;
    logic [TripW-1:0]     trip;
    result_t              expected_q[$];
    int unsigned          errors;
    int unsigned          ticks;
    int unsigned          samples;
    int unsigned          shutdowns;

    function new();
      cutoff      = CutoffReset;
      interval    = IntervalReset;
      sustain     = SustainReset;
      last_sample = '0;
      over_start  = '0;
      trip        = '0;
      errors      = 0;
      ticks       = 0;
      samples     = 0;
      shutdowns   = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      logic [CutoffW-1:0] c;
      c = data[CutoffW-1:0];
      case (idx)
        REG_CUTOFF: begin
          // clamp and restart the over-temperature timer
          cutoff     = (c > CutoffMax) ? CutoffMax : c;
          over_start = '0;
        end
        REG_INTERVAL: interval = data[IntervalW-1:0];
        REG_SUSTAIN:  sustain  = data[SustainW-1:0];
        default: ;
      endcase
    endfunction

    function void note_tick(logic [TimeW-1:0] now, logic signed [TempW-1:0] temp);
      result_t          r;
      logic [TimeW-1:0] since_sample;
      logic [TimeW-1:0] since_over;
      r            = '0;
      since_sample = now - last_sample;
      since_over   = now - over_start;
      ticks++;
      if (cutoff != '0) begin
        if (last_sample == '0 || since_sample >= TimeW'(interval)) begin
          r.sampled   = 1'b1;
          last_sample = now;
          // non-positive readings only move the sample time
          if (temp > 0) begin
            if (temp[TempW-2:0] < cutoff) begin
              over_start = '0;
            end else if (over_start == '0) begin
              over_start = (now == '0) ? TimeW'(1) : now;
            end else if (since_over >= TimeW'(sustain)) begin
              r.shutdown = 1'b1;
              if (trip < TripMax) trip++;
              // power-down forgets both timestamps
              last_sample = '0;
              over_start  = '0;
            end
          end
        end
      end
      r.over_pending = (over_start != '0);
      r.trip_total   = trip;
      if (r.sampled) samples++;
      if (r.shutdown) shutdowns++;
      expected_q.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected, actual %p", $realtime, got);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.sampled !== exp_r.sampled) begin
        $display("%0t: sampled expected %0d actual %0d", $realtime, exp_r.sampled, got.sampled);
        errors++;
      end
      if (got.over_pending !== exp_r.over_pending) begin
        $display("%0t: over_pending expected %0d actual %0d", $realtime,
                 exp_r.over_pending, got.over_pending);
        errors++;
      end
      if (got.shutdown !== exp_r.shutdown) begin
        $display("%0t: shutdown expected %0d actual %0d", $realtime,
                 exp_r.shutdown, got.shutdown);
        errors++;
      end
      if (got.trip_total !== exp_r.trip_total) begin
        $display("%0t: trip_total expected %0d actual %0d", $realtime,
                 exp_r.trip_total, got.trip_total);
        errors++;
      end
    endfunction
  endclass

  logic                      clk_i         = 1'b0;
  logic                      rst_ni        = 1'b0;
  logic                      cfg_valid_i   = 1'b0;
  logic                      cfg_ready_o;
  logic [CfgIdxW-1:0]        cfg_index_i   = REG_CUTOFF;
  logic [CfgDataW-1:0]       cfg_data_i    = '0;
  logic                      in_valid_i    = 1'b0;
  logic                      in_ready_o;
  logic [TimeW-1:0]          time_ms_i     = '0;
  logic signed [TempW-1:0]   temperature_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i   = 1'b0;
  logic                      sampled_o;
  logic                      over_pending_o;
  logic                      shutdown_o;
  logic [TripW-1:0]          trip_total_o;

  cutoff_scoreboard sb = new();
  int unsigned      cycles      = 0;
  int unsigned      burst_left  = 0;
  int unsigned      ready_mode  = 0;
  int unsigned      reg_writes  = 0;

  sustained_overtemp_cutoff dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .time_ms_i      (time_ms_i),
    .temperature_i  (temperature_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sampled_o      (sampled_o),
    .over_pending_o (over_pending_o),
    .shutdown_o     (shutdown_o),
    .trip_total_o   (trip_total_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("** sustained_overtemp_cutoff: FAILED **");
      $finish;
    end
  end

  // receiver stall pattern: always ready, random, or a fixed 3-of-7 hole
  always @(posedge clk_i) begin
    case (ready_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= ($urandom_range(0, 3) != 0);
      default: out_ready_i <= ((cycles % 7) > 2);
    endcase
  end

  // result beats are taken at the next rising edge, sampled here between edges
  always @(negedge clk_i) begin
    result_t got;
    got.sampled      = sampled_o;
    got.over_pending = over_pending_o;
    got.shutdown     = shutdown_o;
    got.trip_total   = trip_total_o;
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(got);
  end

  // present one tick and hold it until accepted, valid stays high afterwards
  task automatic send_tick(input logic [TimeW-1:0] t, input logic signed [TempW-1:0] temp);
    in_valid_i    <= 1'b1;
    time_ms_i     <= t;
    temperature_i <= temp;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    sb.note_tick(t, temp);
    @(posedge clk_i);
  endtask

  // tick inside a burst, with a random gap once the burst runs out
  task automatic emit(input logic [TimeW-1:0] t, input logic signed [TempW-1:0] temp);
    send_tick(t, temp);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
    end else begin
      burst_left--;
    end
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    sb.write_reg(idx, data);
    reg_writes++;
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // stop sending and wait for every outstanding result, plus pipeline slack
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    logic [TimeW-1:0]        t;
    logic signed [TempW-1:0] temp;
    int                      near;
    int unsigned             pick;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    ready_mode = 1;

    // reset settings: first sample at time zero, too early, ignored readings, trip
    emit(32'd0, 8'sd90);
    emit(32'd500, 8'sd90);
    emit(32'd900, 8'sd90);
    emit(32'd1500, 8'sd0);
    emit(32'd2500, -8'sd128);
    emit(32'd3500, 8'sd84);
    emit(32'd4500, 8'sd85);
    emit(32'd14499, 8'sd127);
    emit(32'd15500, 8'sd85);
    emit(32'd15600, HotTemp);
    // timing across the 32-bit wrap
    emit(32'hFFFF_FF00, HotTemp);
    emit(32'hFFFF_FFF0, HotTemp);
    emit(32'h0000_0300, HotTemp);
    emit(32'h0000_1000, HotTemp);
    emit(32'h0000_2800, HotTemp);
    drain();

    // disabled cutoff
    cfg_write(REG_CUTOFF, 24'd0);
    emit(32'h0000_5000, 8'sd127);
    drain();

    // clamped cutoff, zero interval and zero sustain, unused index on the side
    cfg_write(REG_CUTOFF, 24'hFFFF7F);
    cfg_write(REG_INTERVAL, 24'hFF0000);
    cfg_write(REG_SUSTAIN, 24'd0);
    cfg_write(RegUnused, 24'hFFFFFF);
    emit(32'h0000_0100, 8'sd120);
    emit(32'h0000_0100, 8'sd127);
    emit(32'd0, 8'sd120);
    emit(32'd0, 8'sd119);
    drain();

    // lowest cutoff, then the largest interval and sustain
    cfg_write(REG_CUTOFF, 24'd1);
    emit(32'd5, 8'sd1);
    emit(32'd6, 8'sd0);
    emit(32'd7, 8'sd1);
    drain();
    cfg_write(REG_INTERVAL, 24'hABFFFF);
    cfg_write(REG_SUSTAIN, 24'hFFFFFF);
    emit(32'd10, 8'sd50);
    emit(32'd65544, 8'sd50);
    emit(32'd65545, 8'sd50);
    drain();

    // random phases: time mostly advancing, readings mostly near the cutoff
    for (int ph = 0; ph < 6; ph++) begin
      ready_mode = $urandom_range(0, 2);
      pick = $urandom_range(0, 9);
      cfg_write(REG_CUTOFF, (ph == 0) ? 24'h00007F : (ph == 1) ? 24'd1 :
                (pick == 0) ? 24'd0 : 24'($urandom_range(0, 24'hFFFFFF)));
      pick = $urandom_range(0, 4);
      cfg_write(REG_INTERVAL, (ph == 0 || pick == 0) ? 24'd0 :
                (ph == 1 || pick == 1) ? 24'hFFFFFF : 24'($urandom_range(0, 40)));
      pick = $urandom_range(0, 4);
      cfg_write(REG_SUSTAIN, (ph == 0 || pick == 0) ? 24'd0 :
                (ph == 1 || pick == 1) ? 24'hFFFFFF : 24'($urandom_range(0, 300)));
      t = $urandom();
      for (int k = 0; k < 66; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          t = t + $urandom_range(0, 2 * sb.interval + 2);
        end else if (pick < 85) begin
          t = t + $urandom_range(0, sb.sustain / 2 + sb.interval + 1);
        end else if (pick < 96) begin
          t = $urandom();
        end else begin
          t = '0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          near = int'(sb.cutoff) + int'($urandom_range(0, 6)) - 3;
          if (near > 127) near = 127;
          temp = near[TempW-1:0];
        end else if (pick < 85) begin
          temp = TempW'($urandom_range(0, 255));
        end else if (pick < 95) begin
          temp = -$signed(TempW'($urandom_range(0, 128)));
        end else begin
          temp = 8'sd127;
        end
        emit(t, temp);
        // hold off mid-phase until everything outstanding has come back
        if (k == 33 && ph == 2) drain();
      end
      drain();
    end

    // back-to-back trips with no idling at all
    ready_mode = 0;
    cfg_write(REG_CUTOFF, 24'd85);
    cfg_write(REG_INTERVAL, 24'd0);
    cfg_write(REG_SUSTAIN, 24'd0);
    t = 32'h1000_0000;
    for (int k = 0; k < 16; k++) begin
      send_tick(t, HotTemp);
      t++;
    end
    drain();
    repeat (8) @(posedge clk_i);

    $display("ran %0d ticks (%0d sampled, %0d shutdowns) over %0d register writes,",
             sb.ticks, sb.samples, sb.shutdowns, reg_writes);
    $display("including time wrap, clamped and disabled cutoffs and back-to-back trips");
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("** sustained_overtemp_cutoff: PASSED **");
    end else begin
      $display("** sustained_overtemp_cutoff: FAILED **");
    end
    $finish;
  end

endmodule
